// ----- design/mfc_pkg.sv -----
package mfc_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COUNT_W    = 9;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = BYTE_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX           = 9'd511;
    localparam logic [COUNT_W-1:0] FIRST_PAYLOAD_INDEX = 9'd5;
    localparam logic [COUNT_W:0]   FRAME_OVERHEAD      = 10'd6;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST   = 8'd36;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST  = 8'd77;
    localparam logic [BYTE_W-1:0] DIRECTION_CHAR_RST = 8'd62;
    localparam logic [BYTE_W-1:0] EXPECTED_LEN_RST   = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_FIRST   = 2'd0,
        CFG_HEADER_SECOND  = 2'd1,
        CFG_DIRECTION_CHAR = 2'd2,
        CFG_EXPECTED_LEN   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_SHORT  = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_SIZE_BAD   = 3'd3,
        ST_CHECKSUM   = 3'd4
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              is_payload;
        logic              frame_end;
        t_status           status;
        logic [BYTE_W-1:0] msg_code;
        logic              length_unexpected;
    } t_out_item;

endpackage

// ----- design/mfc_stream_if.sv -----
interface mfc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/msp_v1_frame_checker.sv -----
// MSP v1 reply frame checker. Bytes of one received buffer come in on i_in_ch,
// the last one flagged by end_of_buffer. Header bytes are compared against the
// configured header/direction values, length and code are captured, and an XOR
// checksum runs over length, code and payload. Each payload byte goes out at
// once as a provisional result; the last byte of the buffer yields one status
// result (too short, bad header, size inconsistent, checksum error, or ok),
// after which the checker is ready for the next buffer. Throughput is one byte
// per clock: all per-byte work is a compare, a counter step and an XOR feeding
// a single output register, and a byte is taken whenever that register is
// empty or being drained in the same cycle. Configuration writes should be made
// between buffers.
module msp_v1_frame_checker
    import mfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mfc_stream_if.sink            i_in_ch,
    mfc_stream_if.source          o_out_ch
);

    logic [BYTE_W-1:0]  r_header_first, r_header_second, r_direction_char, r_expected_len;
    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic               r_header_bad, n_header_bad;
    logic [BYTE_W-1:0]  r_payload_length, n_payload_length;
    logic [BYTE_W-1:0]  r_code_seen, n_code_seen;
    logic [BYTE_W-1:0]  r_running_xor, n_running_xor;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic              accept;
    logic [BYTE_W-1:0] b;
    logic              hdr_bad;
    logic [COUNT_W:0]  total;
    logic [COUNT_W:0]  payload_end;

    assign i_in_ch.ready    = !r_out_valid || o_out_ch.ready;
    assign accept           = i_in_ch.valid && i_in_ch.ready;
    assign o_out_ch.valid   = r_out_valid;
    assign o_out_ch.payload = r_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first   <= HEADER_FIRST_RST;
            r_header_second  <= HEADER_SECOND_RST;
            r_direction_char <= DIRECTION_CHAR_RST;
            r_expected_len   <= EXPECTED_LEN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HEADER_FIRST:   r_header_first   <= i_cfg_data[BYTE_W-1:0];
                CFG_HEADER_SECOND:  r_header_second  <= i_cfg_data[BYTE_W-1:0];
                CFG_DIRECTION_CHAR: r_direction_char <= i_cfg_data[BYTE_W-1:0];
                CFG_EXPECTED_LEN:   r_expected_len   <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        b           = i_in_ch.payload.rx_byte;
        total       = {1'b0, r_byte_count} + 10'd1;
        payload_end = {1'b0, FIRST_PAYLOAD_INDEX} + {2'b00, r_payload_length};

        hdr_bad = r_header_bad
                || (r_byte_count == 9'd0 && b != r_header_first)
                || (r_byte_count == 9'd1 && b != r_header_second)
                || (r_byte_count == 9'd2 && b != r_direction_char);

        n_byte_count     = r_byte_count;
        n_header_bad     = r_header_bad;
        n_payload_length = r_payload_length;
        n_code_seen      = r_code_seen;
        n_running_xor    = r_running_xor;
        n_out            = r_out;
        n_out_valid      = r_out_valid && !o_out_ch.ready;

        if (accept) begin
            n_out = '0;
            if (!i_in_ch.payload.end_of_buffer) begin
                n_header_bad = hdr_bad;
                if (r_byte_count == 9'd3) n_payload_length = b;
                if (r_byte_count == 9'd4) n_code_seen = b;
                if (r_byte_count >= 9'd3) n_running_xor = r_running_xor ^ b;
                n_byte_count = (r_byte_count < COUNT_MAX) ? r_byte_count + 9'd1 : COUNT_MAX;
                if (!hdr_bad && r_byte_count >= FIRST_PAYLOAD_INDEX
                    && {1'b0, r_byte_count} < payload_end) begin
                    n_out.data_byte  = b;
                    n_out.is_payload = 1'b1;
                    n_out_valid      = 1'b1;
                end
            end else begin
                n_out.frame_end = 1'b1;
                n_out_valid     = 1'b1;
                if (total < FRAME_OVERHEAD) begin
                    n_out.status = ST_TOO_SHORT;
                end else if (hdr_bad) begin
                    n_out.status = ST_BAD_HEADER;
                end else begin
                    n_out.msg_code          = r_code_seen;
                    n_out.length_unexpected = (r_payload_length != r_expected_len);
                    if (total != FRAME_OVERHEAD + {2'b00, r_payload_length})
                        n_out.status = ST_SIZE_BAD;
                    else if (r_running_xor != b)
                        n_out.status = ST_CHECKSUM;
                    else
                        n_out.status = ST_OK;
                end
                // back to a clean frame
                n_byte_count     = '0;
                n_header_bad     = 1'b0;
                n_payload_length = '0;
                n_code_seen      = '0;
                n_running_xor    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count     <= '0;
            r_header_bad     <= 1'b0;
            r_payload_length <= '0;
            r_code_seen      <= '0;
            r_running_xor    <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_byte_count     <= n_byte_count;
            r_header_bad     <= n_header_bad;
            r_payload_length <= n_payload_length;
            r_code_seen      <= n_code_seen;
            r_running_xor    <= n_running_xor;
            r_out_valid      <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule
